// ===== sv/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int ROOT_WIDTH     = 32;
  localparam int Q_FRAC         = 16;

  typedef enum logic [1:0] {
    KIND_DISTINCT = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_NO_QUAD  = 2'd3
  } root_kind_t;

endpackage

`default_nettype wire

// ===== sv/qrs_coef_if.sv =====
// ----------------------------------------------------------------------------
// qrs_coef_if
// Coefficient channel: valid/ready with a, b and c as signed Q8.8.
// ----------------------------------------------------------------------------
`default_nettype none

interface qrs_coef_if #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source(output valid, coef_a, coef_b, coef_c, input ready);
  modport sink(input valid, coef_a, coef_b, coef_c, output ready);
endinterface

`default_nettype wire

// ===== sv/qrs_root_if.sv =====
// ----------------------------------------------------------------------------
// qrs_root_if
// Result channel: valid/ready with the root kind and two Q16.16 roots.
// ----------------------------------------------------------------------------
`default_nettype none

interface qrs_root_if;
  logic                                      valid;
  logic                                      ready;
  qrs_pkg::root_kind_t                       root_kind;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0]     root_first;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0]     root_second;

  modport source(output valid, root_kind, root_first, root_second, input ready);
  modport sink(input valid, root_kind, root_first, root_second, output ready);
endinterface

`default_nettype wire

// ===== sv/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c = 0 from signed Q8.8 coefficients.
//
// coef (sink) takes one coefficient set per transaction; roots (source)
// returns one result per set: the root kind and two signed Q16.16 values,
// truncated toward zero and saturated. A zero leading coefficient gives
// kind 3 and two zero roots.
// The pipeline holds the input, product and discriminant registers,
// COEF_WIDTH+1 square root cells, a numerator setup register,
// COEF_WIDTH+18 divider cells and the output register.
// Throughput is one transaction per cycle while roots does not stall;
// every stage holds one set. When roots stalls, each full stage holds
// while empty stages still fill, so coef stays ready until the whole
// pipeline is full. Synchronous reset empties it; payload is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  qrs_coef_if.sink   coef,
  qrs_root_if.source roots
);

  localparam int W   = COEF_WIDTH;
  localparam int SW  = W + 1;
  localparam int DW  = 2 * SW;
  localparam int XW  = 2 * W + 2;
  localparam int NW  = W + 2 + qrs_pkg::Q_FRAC;
  localparam int DVW = W + 1;
  localparam int L   = 5 + SW + NW;
  localparam int RW  = qrs_pkg::ROOT_WIDTH;
  localparam int QW  = (NW > RW + 1) ? NW : RW + 1;
  localparam int SQ0 = 3;
  localparam int NST = 3 + SW;
  localparam int DV0 = 4 + SW;

  logic [L-1:0] v;
  logic [L:0]   en;

  always_comb begin
    en[L] = roots.ready;
    for (int i = L - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign coef.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= coef.valid;
      end
      for (int i = 1; i < L; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // input register
  logic signed [W-1:0] a0, b0, c0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0 <= coef.coef_a;
      b0 <= coef.coef_b;
      c0 <= coef.coef_c;
    end
  end

  // products
  logic [W-1:0]        ma0, mb0, mc0;
  logic [2*W-1:0]      p_b2, p_ac;
  logic                p_acpos;
  logic signed [W-1:0] p_a, p_b;

  always_comb begin
    ma0 = a0[W-1] ? W'(-a0) : W'(a0);
    mb0 = b0[W-1] ? W'(-b0) : W'(b0);
    mc0 = c0[W-1] ? W'(-c0) : W'(c0);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_b2    <= mb0 * mb0;
      p_ac    <= ma0 * mc0;
      p_acpos <= (a0 != '0) && (c0 != '0) && (a0[W-1] == c0[W-1]);
      p_a     <= a0;
      p_b     <= b0;
    end
  end

  // discriminant
  logic [DW-1:0]       q4, b2x, d_next;
  logic                neg_next;
  logic [DW-1:0]       d_d;
  logic                d_neg, d_zero;
  logic signed [W-1:0] d_a, d_b;

  always_comb begin
    q4  = {p_ac, 2'b00};
    b2x = DW'(p_b2);
    if (!p_acpos) begin
      d_next   = b2x + q4;
      neg_next = 1'b0;
    end else if (q4 <= b2x) begin
      d_next   = b2x - q4;
      neg_next = 1'b0;
    end else begin
      d_next   = q4 - b2x;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d_d    <= d_next;
      d_neg  <= neg_next;
      d_zero <= !neg_next && (d_next == '0);
      d_a    <= p_a;
      d_b    <= p_b;
    end
  end

  // square root chain
  logic [SW+1:0] sq_rem  [0:SW];
  logic [SW-1:0] sq_root [0:SW];
  logic [DW-1:0] sq_rad  [0:SW];
  logic [XW-1:0] sq_side [0:SW];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = d_d;
  assign sq_side[0] = {d_neg, d_zero, d_a, d_b};

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW), .XW(XW)) u_cell (
      .clk      (clk),
      .en       (en[SQ0+k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .rad_in   (sq_rad[k]),
      .side_in  (sq_side[k]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .rad_out  (sq_rad[k+1]),
      .side_out (sq_side[k+1])
    );
  end

  // numerators and divisor
  logic                s_neg, s_zero;
  logic signed [W-1:0] s_a, s_b;
  logic signed [W+2:0] nb, sv, t1, t2, m1, m2;
  logic [W-1:0]        sma;
  qrs_pkg::root_kind_t kind_next;

  logic [NW-1:0]       n_num1, n_num2;
  logic [DVW-1:0]      n_den;
  qrs_pkg::root_kind_t n_kind;
  logic                n_neg1, n_neg2;

  always_comb begin
    {s_neg, s_zero, s_a, s_b} = sq_side[SW];
    nb  = -$signed({{3{s_b[W-1]}}, s_b});
    sv  = $signed({2'b00, sq_root[SW]});
    sma = s_a[W-1] ? W'(-s_a) : W'(s_a);
    if (s_a == '0) begin
      kind_next = qrs_pkg::KIND_NO_QUAD;
    end else if (s_neg) begin
      kind_next = qrs_pkg::KIND_COMPLEX;
    end else if (s_zero) begin
      kind_next = qrs_pkg::KIND_DOUBLE;
    end else begin
      kind_next = qrs_pkg::KIND_DISTINCT;
    end
    case (kind_next)
      qrs_pkg::KIND_DISTINCT: begin
        t1 = nb + sv;
        t2 = nb - sv;
      end
      qrs_pkg::KIND_COMPLEX: begin
        t1 = nb;
        t2 = sv;
      end
      default: begin
        t1 = nb;
        t2 = nb;
      end
    endcase
    m1 = t1[W+2] ? -t1 : t1;
    m2 = t2[W+2] ? -t2 : t2;
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      n_num1 <= {m1[W+1:0], {qrs_pkg::Q_FRAC{1'b0}}};
      n_num2 <= {m2[W+1:0], {qrs_pkg::Q_FRAC{1'b0}}};
      n_den  <= {sma, 1'b0};
      n_kind <= kind_next;
      n_neg1 <= t1[W+2] ^ s_a[W-1];
      n_neg2 <= t2[W+2] ^ s_a[W-1];
    end
  end

  // divider chains
  logic [NW-1:0]  dv1_nq [0:NW], dv2_nq [0:NW];
  logic [DVW-1:0] dv1_rem[0:NW], dv2_rem[0:NW];
  logic [DVW-1:0] dv1_den[0:NW], dv2_den[0:NW];
  logic [2:0]     dv1_side[0:NW];
  logic [0:0]     dv2_side[0:NW];

  assign dv1_nq[0]   = n_num1;
  assign dv2_nq[0]   = n_num2;
  assign dv1_rem[0]  = '0;
  assign dv2_rem[0]  = '0;
  assign dv1_den[0]  = n_den;
  assign dv2_den[0]  = n_den;
  assign dv1_side[0] = {n_kind, n_neg1};
  assign dv2_side[0] = n_neg2;

  for (genvar k = 0; k < NW; k++) begin : g_div
    qrs_div_cell #(.NW(NW), .DVW(DVW), .XW(3)) u_first (
      .clk      (clk),
      .en       (en[DV0+k]),
      .nq_in    (dv1_nq[k]),
      .rem_in   (dv1_rem[k]),
      .den_in   (dv1_den[k]),
      .side_in  (dv1_side[k]),
      .nq_out   (dv1_nq[k+1]),
      .rem_out  (dv1_rem[k+1]),
      .den_out  (dv1_den[k+1]),
      .side_out (dv1_side[k+1])
    );
    qrs_div_cell #(.NW(NW), .DVW(DVW), .XW(1)) u_second (
      .clk      (clk),
      .en       (en[DV0+k]),
      .nq_in    (dv2_nq[k]),
      .rem_in   (dv2_rem[k]),
      .den_in   (dv2_den[k]),
      .side_in  (dv2_side[k]),
      .nq_out   (dv2_nq[k+1]),
      .rem_out  (dv2_rem[k+1]),
      .den_out  (dv2_den[k+1]),
      .side_out (dv2_side[k+1])
    );
  end

  // sign and saturation
  localparam logic [QW-1:0] POS_MAX = QW'({1'b0, {(RW-1){1'b1}}});
  localparam logic [QW-1:0] NEG_MAX = QW'({1'b1, {(RW-1){1'b0}}});

  qrs_pkg::root_kind_t o_kind;
  logic [QW-1:0]       qx1, qx2, nx1, nx2;
  logic [RW-1:0]       r1, r2;
  logic                o_neg1;

  always_comb begin
    o_kind = qrs_pkg::root_kind_t'(dv1_side[NW][2:1]);
    o_neg1 = dv1_side[NW][0];
    qx1 = QW'(dv1_nq[NW]);
    qx2 = QW'(dv2_nq[NW]);
    nx1 = -qx1;
    nx2 = -qx2;
    if (o_neg1) begin
      r1 = (qx1 > NEG_MAX) ? NEG_MAX[RW-1:0] : nx1[RW-1:0];
    end else begin
      r1 = (qx1 > POS_MAX) ? POS_MAX[RW-1:0] : qx1[RW-1:0];
    end
    if (dv2_side[NW][0]) begin
      r2 = (qx2 > NEG_MAX) ? NEG_MAX[RW-1:0] : nx2[RW-1:0];
    end else begin
      r2 = (qx2 > POS_MAX) ? POS_MAX[RW-1:0] : qx2[RW-1:0];
    end
    if (o_kind == qrs_pkg::KIND_NO_QUAD) begin
      r1 = '0;
      r2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[L-1]) begin
      roots.root_kind   <= o_kind;
      roots.root_first  <= r1;
      roots.root_second <= r2;
    end
  end

  assign roots.valid = v[L-1];

  a_no_quad_zero: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_kind == qrs_pkg::KIND_NO_QUAD |->
      roots.root_first == '0 && roots.root_second == '0)
    else $error("leading coefficient zero with nonzero roots");

  a_double_equal: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_kind == qrs_pkg::KIND_DOUBLE |->
      roots.root_first == roots.root_second)
    else $error("double root with unequal roots");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    coef.valid && coef.ready |=> v[0])
    else $error("accepted transaction missing from first stage");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    !coef.ready |-> (&v) && !roots.ready)
    else $error("input stalled while pipeline has room");

endmodule

`default_nettype wire

// ===== sv/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One root bit of a floor square root; carries side data along.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell #(
  parameter int SW  = 17,
  parameter int XW  = 34
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SW+1:0]     rem_in,
  input  wire logic [SW-1:0]     root_in,
  input  wire logic [2*SW-1:0]   rad_in,
  input  wire logic [XW-1:0]     side_in,
  output logic      [SW+1:0]     rem_out,
  output logic      [SW-1:0]     root_out,
  output logic      [2*SW-1:0]   rad_out,
  output logic      [XW-1:0]     side_out
);

  logic [SW+3:0] trial;
  logic [SW+3:0] cand;
  logic [SW+3:0] diff;
  logic          ge;

  always_comb begin
    trial = {rem_in, rad_in[2*SW-1:2*SW-2]};
    cand  = {2'b00, root_in, 2'b01};
    ge    = trial >= cand;
    diff  = ge ? trial - cand : trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= diff[SW+1:0];
      root_out <= {root_in[SW-2:0], ge};
      rad_out  <= {rad_in[2*SW-3:0], 2'b00};
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_div_cell
// One quotient bit of an unsigned restoring division; carries side data.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell #(
  parameter int NW  = 34,
  parameter int DVW = 17,
  parameter int XW  = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NW-1:0]    nq_in,
  input  wire logic [DVW-1:0]   rem_in,
  input  wire logic [DVW-1:0]   den_in,
  input  wire logic [XW-1:0]    side_in,
  output logic      [NW-1:0]    nq_out,
  output logic      [DVW-1:0]   rem_out,
  output logic      [DVW-1:0]   den_out,
  output logic      [XW-1:0]    side_out
);

  logic [DVW:0] trial;
  logic [DVW:0] diff;
  logic         ge;

  always_comb begin
    trial = {rem_in, nq_in[NW-1]};
    ge    = trial >= {1'b0, den_in};
    diff  = ge ? trial - {1'b0, den_in} : trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq_out   <= {nq_in[NW-2:0], ge};
      rem_out  <= diff[DVW-1:0];
      den_out  <= den_in;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire
